// File: rtl/attitude_altitude_pd_motor_mixer_assert.svh
// Assertion macros used by the checker of the attitude and altitude motor mixer.
// Each macro expects a signal named clk, and the first two also rst_n, in the scope where it is used.
`ifndef ATTITUDE_ALTITUDE_PD_MOTOR_MIXER_ASSERT_SVH
`define ATTITUDE_ALTITUDE_PD_MOTOR_MIXER_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define AAPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define AAPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define AAPD_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/aapd_pkg.sv
// Shared types and constants of the attitude and altitude PD motor mixer.
// Depends on nothing; used by the top level and the mixer stages.
package aapd_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_ALT_PROP   = 3'd0;
  localparam logic [2:0] REG_ALT_DERIV  = 3'd1;
  localparam logic [2:0] REG_TILT_PROP  = 3'd2;
  localparam logic [2:0] REG_TILT_DERIV = 3'd3;
  localparam logic [2:0] REG_YAW_PROP   = 3'd4;
  localparam logic [2:0] REG_YAW_DERIV  = 3'd5;

  // Register reset values, unsigned Q8.8.
  localparam logic [15:0] ALT_PROP_RST   = 16'd256;
  localparam logic [15:0] ALT_DERIV_RST  = 16'd512;
  localparam logic [15:0] TILT_PROP_RST  = 16'd2560;
  localparam logic [15:0] TILT_DERIV_RST = 16'd768;
  localparam logic [15:0] YAW_PROP_RST   = 16'd1024;
  localparam logic [15:0] YAW_DERIV_RST  = 16'd384;

  // Physical constants in fixed point.
  localparam logic signed [28:0] G_Q24         = 29'sd164580311;
  localparam logic signed [16:0] MASS_Q16      = 17'sd50463;
  localparam logic signed [15:0] TILT_COEF_Q24 = 16'sd31457;
  localparam logic signed [15:0] YAW_COEF_Q24  = 16'sd8924;

  // Limits.
  localparam logic signed [26:0] AD_MAX_Q24     = 27'sd33554432;
  localparam logic signed [26:0] AD_MIN_Q24     = -27'sd50331648;
  localparam logic signed [29:0] THRUST_MAX_Q24 = 30'sd268435456;
  localparam logic [15:0]        THROTTLE_MAX   = 16'hFFFF;

  // Products handed from the control law to the mixer.
  typedef struct packed {
    logic signed [44:0] thrust_prod;  // (g + aD) * mass, Q.40
    logic signed [56:0] roll_term;    // Q.48
    logic signed [56:0] pitch_term;   // Q.48
    logic signed [56:0] yaw_term;     // Q.48
  } mix_data_t;

endpackage

// File: rtl/aapd_mixer.sv
// Thrust rounding, X mixer and throttle saturation: the last three pipeline stages.
// Depends on aapd_pkg for the product struct and the limits.
module aapd_mixer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mix_valid,
  output logic                mix_ready,
  input  aapd_pkg::mix_data_t mix_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_motor_one,
  output logic [15:0]         out_motor_two,
  output logic [15:0]         out_motor_three,
  output logic [15:0]         out_motor_four
);

  localparam logic signed [59:0] ROUND_HALF = 60'sh0_0000_8000_0000;

  logic [2:0] vld_r;
  logic [2:0] en;

  // Stage 5 registers.
  logic [28:0]        thrust_r;
  logic signed [56:0] roll_r;
  logic signed [57:0] pm_sum_r;
  logic signed [57:0] pm_dif_r;
  logic [28:0]        thrust_nxt;
  logic signed [44:0] thr_rnd;

  // Stage 6 registers.
  logic signed [59:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [59:0] m1_nxt, m2_nxt, m3_nxt, m4_nxt;
  logic signed [59:0] base;

  // Stage 7 registers.
  logic [15:0] th1_r, th2_r, th3_r, th4_r;

  function automatic logic [15:0] sat_throttle(input logic signed [59:0] m);
    logic [15:0] res;
    if (m[59]) begin
      res = '0;
    end else if (|m[58:48]) begin
      res = aapd_pkg::THROTTLE_MAX;
    end else begin
      res = m[47:32];
    end
    return res;
  endfunction

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    en[2] = !vld_r[2] || out_ready;
    en[1] = !vld_r[1] || en[2];
    en[0] = !vld_r[0] || en[1];
  end

  assign mix_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= mix_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_comb begin
    thr_rnd = (mix_data.thrust_prod + 45'sd32768) >>> 16;
    if (thr_rnd < 45'sd0) begin
      thrust_nxt = '0;
    end else if (thr_rnd > 45'(aapd_pkg::THRUST_MAX_Q24)) begin
      thrust_nxt = 29'(aapd_pkg::THRUST_MAX_Q24);
    end else begin
      thrust_nxt = thr_rnd[28:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      thrust_r <= thrust_nxt;
      roll_r   <= mix_data.roll_term;
      pm_sum_r <= 58'(mix_data.pitch_term) + 58'(mix_data.yaw_term);
      pm_dif_r <= 58'(mix_data.pitch_term) - 58'(mix_data.yaw_term);
    end
  end

  // Thrust / 16 in Q.48 is the Q.24 thrust shifted left by 20.
  always_comb begin
    base   = $signed({11'b0, thrust_r, 20'b0});
    m1_nxt = base - 60'(roll_r) + 60'(pm_sum_r) + ROUND_HALF;
    m2_nxt = base - 60'(roll_r) - 60'(pm_sum_r) + ROUND_HALF;
    m3_nxt = base + 60'(roll_r) - 60'(pm_dif_r) + ROUND_HALF;
    m4_nxt = base + 60'(roll_r) + 60'(pm_dif_r) + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      m3_r <= m3_nxt;
      m4_r <= m4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      th1_r <= sat_throttle(m1_r);
      th2_r <= sat_throttle(m2_r);
      th3_r <= sat_throttle(m3_r);
      th4_r <= sat_throttle(m4_r);
    end
  end

  assign out_valid       = vld_r[2];
  assign out_motor_one   = th1_r;
  assign out_motor_two   = th2_r;
  assign out_motor_three = th3_r;
  assign out_motor_four  = th4_r;

endmodule

// File: rtl/attitude_altitude_pd_motor_mixer.sv
// Top level of the attitude and altitude PD controller with X motor mixer.
// Depends on aapd_pkg and aapd_mixer.

// One beat in, one beat out. A new sample is taken in every cycle while the output
// is not stalled, because every stage can then advance in every cycle. The seven
// pipeline stages are: error forming, gain multiplies, PD sums with the vertical
// acceleration clamp, thrust and mixer coefficient multiplies, thrust rounding,
// motor sums and throttle saturation. Each stage holds its beat when the stage
// after it is full and stalled, so bubbles close up and in_ready stays high while
// the output is empty or being taken. Gains are written through the cfg port and
// must only change while the pipeline is empty.
module attitude_altitude_pd_motor_mixer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_roll_target,
  input  logic signed [23:0] in_pitch_target,
  input  logic signed [23:0] in_height_target,
  input  logic signed [23:0] in_climb_target,
  input  logic signed [23:0] in_roll_angle,
  input  logic signed [23:0] in_pitch_angle,
  input  logic signed [23:0] in_yaw_angle,
  input  logic signed [23:0] in_roll_rate,
  input  logic signed [23:0] in_pitch_rate,
  input  logic signed [23:0] in_yaw_rate,
  input  logic signed [23:0] in_height,
  input  logic signed [23:0] in_down_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_motor_one,
  output logic [15:0]        out_motor_two,
  output logic [15:0]        out_motor_three,
  output logic [15:0]        out_motor_four
);

  logic [15:0] alt_prop_gain_r, alt_deriv_gain_r;
  logic [15:0] tilt_prop_gain_r, tilt_deriv_gain_r;
  logic [15:0] yaw_prop_gain_r, yaw_deriv_gain_r;

  logic [3:0] vld_r;
  logic [3:0] en;
  logic       mix_ready;

  // Stage 1: errors and passed-through measurements.
  logic signed [24:0] eh_r, ec_r, er_r, ep_r;
  logic signed [23:0] yaw_r, p_r, q_r, r_r;

  // Stage 2: gain products, Q.24.
  logic signed [40:0] pa_r, pd_r, pr_r, pdr_r, pp_r, pdq_r, py_r, pdy_r;

  // Stage 3: clamped vertical acceleration and PD efforts.
  logic signed [26:0] ad_r;
  logic signed [41:0] u_roll_r, u_pitch_r, u_yaw_r;
  logic signed [26:0] ad_nxt;
  logic signed [41:0] ad_sum;

  // Stage 4: products for the mixer.
  aapd_pkg::mix_data_t mix_r;
  aapd_pkg::mix_data_t mix_nxt;
  logic signed [28:0]  gsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_prop_gain_r   <= aapd_pkg::ALT_PROP_RST;
      alt_deriv_gain_r  <= aapd_pkg::ALT_DERIV_RST;
      tilt_prop_gain_r  <= aapd_pkg::TILT_PROP_RST;
      tilt_deriv_gain_r <= aapd_pkg::TILT_DERIV_RST;
      yaw_prop_gain_r   <= aapd_pkg::YAW_PROP_RST;
      yaw_deriv_gain_r  <= aapd_pkg::YAW_DERIV_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        aapd_pkg::REG_ALT_PROP:   alt_prop_gain_r   <= cfg_data;
        aapd_pkg::REG_ALT_DERIV:  alt_deriv_gain_r  <= cfg_data;
        aapd_pkg::REG_TILT_PROP:  tilt_prop_gain_r  <= cfg_data;
        aapd_pkg::REG_TILT_DERIV: tilt_deriv_gain_r <= cfg_data;
        aapd_pkg::REG_YAW_PROP:   yaw_prop_gain_r   <= cfg_data;
        aapd_pkg::REG_YAW_DERIV:  yaw_deriv_gain_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    en[3] = !vld_r[3] || mix_ready;
    en[2] = !vld_r[2] || en[3];
    en[1] = !vld_r[1] || en[2];
    en[0] = !vld_r[0] || en[1];
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
      if (en[3]) vld_r[3] <= vld_r[2];
    end
  end

  // Climb error adds the down speed because the climb target is positive up.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      eh_r  <= 25'(in_height_target) - 25'(in_height);
      ec_r  <= 25'(in_climb_target) + 25'(in_down_speed);
      er_r  <= 25'(in_roll_target) - 25'(in_roll_angle);
      ep_r  <= 25'(in_pitch_target) - 25'(in_pitch_angle);
      yaw_r <= in_yaw_angle;
      p_r   <= in_roll_rate;
      q_r   <= in_pitch_rate;
      r_r   <= in_yaw_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pa_r  <= 41'($signed({1'b0, alt_prop_gain_r})) * 41'(eh_r);
      pd_r  <= 41'($signed({1'b0, alt_deriv_gain_r})) * 41'(ec_r);
      pr_r  <= 41'($signed({1'b0, tilt_prop_gain_r})) * 41'(er_r);
      pdr_r <= 41'($signed({1'b0, tilt_deriv_gain_r})) * 41'(p_r);
      pp_r  <= 41'($signed({1'b0, tilt_prop_gain_r})) * 41'(ep_r);
      pdq_r <= 41'($signed({1'b0, tilt_deriv_gain_r})) * 41'(q_r);
      py_r  <= 41'($signed({1'b0, yaw_prop_gain_r})) * 41'(yaw_r);
      pdy_r <= 41'($signed({1'b0, yaw_deriv_gain_r})) * 41'(r_r);
    end
  end

  always_comb begin
    ad_sum = 42'(pa_r) + 42'(pd_r);
    if (ad_sum < 42'(aapd_pkg::AD_MIN_Q24)) begin
      ad_nxt = aapd_pkg::AD_MIN_Q24;
    end else if (ad_sum > 42'(aapd_pkg::AD_MAX_Q24)) begin
      ad_nxt = aapd_pkg::AD_MAX_Q24;
    end else begin
      ad_nxt = ad_sum[26:0];
    end
  end

  // The yaw target and all rate targets are zero.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      ad_r      <= ad_nxt;
      u_roll_r  <= 42'(pr_r) - 42'(pdr_r);
      u_pitch_r <= 42'(pp_r) - 42'(pdq_r);
      u_yaw_r   <= -42'(py_r) - 42'(pdy_r);
    end
  end

  always_comb begin
    gsum                = aapd_pkg::G_Q24 + 29'(ad_r);
    mix_nxt.thrust_prod = 45'(gsum) * 45'(aapd_pkg::MASS_Q16);
    mix_nxt.roll_term   = 57'(aapd_pkg::TILT_COEF_Q24) * 57'(u_roll_r);
    mix_nxt.pitch_term  = 57'(aapd_pkg::TILT_COEF_Q24) * 57'(u_pitch_r);
    mix_nxt.yaw_term    = 57'(aapd_pkg::YAW_COEF_Q24) * 57'(u_yaw_r);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      mix_r <= mix_nxt;
    end
  end

  aapd_mixer u_mixer (
    .clk             (clk),
    .rst_n           (rst_n),
    .mix_valid       (vld_r[3]),
    .mix_ready       (mix_ready),
    .mix_data        (mix_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_motor_one   (out_motor_one),
    .out_motor_two   (out_motor_two),
    .out_motor_three (out_motor_three),
    .out_motor_four  (out_motor_four)
  );

endmodule

// File: rtl/aapd_checker.sv
// Port-level checker for the attitude and altitude PD motor mixer, bound to the top.
// Depends on attitude_altitude_pd_motor_mixer_assert.svh for the assertion macros.
`include "attitude_altitude_pd_motor_mixer_assert.svh"

module aapd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_motor_one,
  input logic [15:0] out_motor_two,
  input logic [15:0] out_motor_three,
  input logic [15:0] out_motor_four
);

  logic in_beat;

  // The input beat itself is not checked here; it only feeds the ready rule below.
  assign in_beat = in_valid && in_ready;

  // The output stage never drops or changes a beat that is waiting.
  `AAPD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "output beat dropped")
  `AAPD_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_motor_one) && $stable(out_motor_two) && $stable(out_motor_three) && $stable(out_motor_four), "output changed while stalled")

  // When the output register is free or draining, the pipeline must take new samples.
  `AAPD_ASSERT_IMP(a_ready_free, !out_valid || out_ready, in_ready || in_beat, "input stalled without backpressure")

  // Reset empties the pipeline.
  `AAPD_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "output valid after reset")

endmodule

bind attitude_altitude_pd_motor_mixer aapd_checker u_aapd_checker (.*);
